// ===== src/differential_motor_command_select_unit_macros.svh =====
// Assertion helpers shared by the block.
`ifndef DIFFERENTIAL_MOTOR_COMMAND_SELECT_UNIT_MACROS_SVH
`define DIFFERENTIAL_MOTOR_COMMAND_SELECT_UNIT_MACROS_SVH

// same-cycle implication
`define DMCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DMCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/dmcs_pkg.sv =====
`timescale 1ns / 1ps
package dmcs_pkg;

   localparam int unsigned DutyWidth = 16;
   localparam int unsigned CalcWidth = 20;   // covers base + corr + trim, signed

   typedef enum logic [1:0] {
      DIR_COAST = 2'd0,
      DIR_FWD   = 2'd1,
      DIR_REV   = 2'd2
   } dir_type;

   // register indexes
   localparam logic [2:0] CSR_BASE_DUTY       = 3'd0;
   localparam logic [2:0] CSR_CORRECTION_DUTY = 3'd1;
   localparam logic [2:0] CSR_PIVOT_DUTY      = 3'd2;
   localparam logic [2:0] CSR_LEFT_TRIM       = 3'd3;
   localparam logic [2:0] CSR_RIGHT_TRIM      = 3'd4;
   localparam logic [2:0] CSR_MAX_DUTY        = 3'd5;

   // route actions
   localparam logic [3:0] ACT_STRAIGHT   = 4'd1;
   localparam logic [3:0] ACT_LEFT       = 4'd2;
   localparam logic [3:0] ACT_RIGHT      = 4'd3;
   localparam logic [3:0] ACT_AROUND     = 4'd4;
   localparam logic [3:0] ACT_STOP_FIRST = 4'd5;
   localparam logic [3:0] ACT_STOP_LAST  = 4'd9;

   // line sensor codes
   localparam logic [2:0] LINE_CENTERED   = 3'd2;
   localparam logic [2:0] LINE_LEFT_ONLY  = 3'd3;
   localparam logic [2:0] LINE_RIGHT_ONLY = 3'd4;

   // vehicle states
   localparam logic [3:0] ST_TURN_LAST   = 4'd2;
   localparam logic [3:0] ST_COMMON_LINE = 4'd3;
   localparam logic [3:0] ST_MOVE_FIRST  = 4'd4;
   localparam logic [3:0] ST_MOVE_LAST   = 4'd6;

   typedef struct packed {
      logic [DutyWidth-1:0]        base_duty;
      logic [DutyWidth-1:0]        correction_duty;
      logic [DutyWidth-1:0]        pivot_duty;
      logic signed [DutyWidth-1:0] left_trim;
      logic signed [DutyWidth-1:0] right_trim;
      logic [DutyWidth-1:0]        max_duty;
   } cfg_type;

   typedef struct packed {
      logic                        mode;
      logic [3:0]                  control_state;
      logic [3:0]                  queued_action;
      logic [2:0]                  line_code;
      logic                        route_enabled;
      logic                        safety_stop;
      logic [DutyWidth-1:0]        direct_base;
      logic signed [DutyWidth-1:0] direct_correction;
   } item_type;

   typedef struct packed {
      logic [DutyWidth-1:0] left_duty;
      logic [DutyWidth-1:0] right_duty;
      dir_type              left_dir;
      dir_type              right_dir;
      logic                 driver_enable;
   } cmd_type;

   localparam cmd_type CMD_STOP = '{
      left_duty: '0, right_duty: '0,
      left_dir: DIR_COAST, right_dir: DIR_COAST, driver_enable: 1'b0};

   function automatic logic [DutyWidth-1:0] clamp_duty(
      input logic signed [CalcWidth-1:0] d,
      input logic [DutyWidth-1:0]        max_duty);
      logic signed [CalcWidth-1:0] max_ext;
      max_ext = signed'({{(CalcWidth-DutyWidth){1'b0}}, max_duty});
      if (d <= 0) begin
         return '0;
      end else if (d >= max_ext) begin
         return max_duty;
      end else begin
         return d[DutyWidth-1:0];
      end
   endfunction

endpackage

// ===== src/differential_motor_command_select_unit.sv =====
`timescale 1ns / 1ps
// channel | direction | contents
// req_    | in        | tuser: mode; tdata: state, action, line, flags, direct base/corr
// rsp_    | out       | tuser: updated; tdata: duties, directions, driver enable
// csr_    | in        | write enable, register index, 16-bit write data
//
// One transaction in and one out per cycle while the result is not stalled; each passes
// the input register, then the decision/trim/clamp logic into the result register.
// The held command feeds the next transaction directly, so back-to-back items chain.
// Synchronous reset returns the config registers to their defaults and the held command to stop.
// A stalled result keeps one transaction parked in the input register; req_tready drops
// only when both registers are full and rsp_tready is low.
`include "differential_motor_command_select_unit_macros.svh"
module differential_motor_command_select_unit
   import dmcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] control_state, [7:4] queued_action, [10:8] line_code,
   // [11] route_enabled, [12] safety_stop, [28:13] direct_base,
   // [44:29] direct_correction, [47:45] zero
   input  logic [47:0] req_tdata,
   // [0] mode
   input  logic        req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] left_duty, [31:16] right_duty, [33:32] left_dir,
   // [35:34] right_dir, [36] driver_enable, [39:37] zero
   output logic [39:0] rsp_tdata,
   // [0] updated
   output logic        rsp_tuser,

   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type  cfg_ff;
   item_type item_ff;
   logic     item_valid_ff;
   cmd_type  held_ff;
   cmd_type  out_cmd_ff;
   logic     out_upd_ff;
   logic     rsp_valid_ff;

   cmd_type  cmd_in;
   logic     upd_in;
   logic     advance;
   logic     req_fire;

   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_duty       <= 16'd400;
         cfg_ff.correction_duty <= 16'd150;
         cfg_ff.pivot_duty      <= 16'd300;
         cfg_ff.left_trim       <= '0;
         cfg_ff.right_trim      <= '0;
         cfg_ff.max_duty        <= 16'd999;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BASE_DUTY:       cfg_ff.base_duty       <= csr_wdata;
            CSR_CORRECTION_DUTY: cfg_ff.correction_duty <= csr_wdata;
            CSR_PIVOT_DUTY:      cfg_ff.pivot_duty      <= csr_wdata;
            CSR_LEFT_TRIM:       cfg_ff.left_trim       <= signed'(csr_wdata);
            CSR_RIGHT_TRIM:      cfg_ff.right_trim      <= signed'(csr_wdata);
            CSR_MAX_DUTY:        cfg_ff.max_duty        <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.mode              <= req_tuser;
         item_ff.control_state     <= req_tdata[3:0];
         item_ff.queued_action     <= req_tdata[7:4];
         item_ff.line_code         <= req_tdata[10:8];
         item_ff.route_enabled     <= req_tdata[11];
         item_ff.safety_stop       <= req_tdata[12];
         item_ff.direct_base       <= req_tdata[28:13];
         item_ff.direct_correction <= signed'(req_tdata[44:29]);
      end
   end

   dmcs_cmd u_cmd (
      .cfg     (cfg_ff),
      .item    (item_ff),
      .held    (held_ff),
      .cmd     (cmd_in),
      .updated (upd_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= CMD_STOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            held_ff <= cmd_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_cmd_ff <= cmd_in;
         out_upd_ff <= upd_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_upd_ff;
   assign rsp_tdata  = {3'b000, out_cmd_ff.driver_enable, out_cmd_ff.right_dir,
                        out_cmd_ff.left_dir, out_cmd_ff.right_duty, out_cmd_ff.left_duty};

   // a standby command is always a full coast stop
   `DMCS_ASSERT_NOW(a_standby_is_stop, clock, reset,
      rsp_valid_ff && !out_cmd_ff.driver_enable,
      out_cmd_ff.left_duty == '0 && out_cmd_ff.right_duty == '0 &&
      out_cmd_ff.left_dir == DIR_COAST && out_cmd_ff.right_dir == DIR_COAST,
      "standby command with nonzero drive")
   // an enabled driver never coasts a wheel
   `DMCS_ASSERT_NOW(a_enable_dir, clock, reset,
      rsp_valid_ff && out_cmd_ff.driver_enable,
      out_cmd_ff.left_dir != DIR_COAST && out_cmd_ff.right_dir != DIR_COAST,
      "enabled command with coasting wheel")
   // a parked item is not dropped while the result stalls
   `DMCS_ASSERT_NEXT(a_no_drop, clock, reset,
      item_valid_ff && rsp_valid_ff && !rsp_tready,
      item_valid_ff && rsp_valid_ff,
      "transaction lost under output stall")

endmodule

// ===== src/dmcs_cmd.sv =====
`timescale 1ns / 1ps
module dmcs_cmd
   import dmcs_pkg::*;
(
   input  cfg_type  cfg,
   input  item_type item,
   input  cmd_type  held,
   output cmd_type  cmd,
   output logic     updated
);

   logic signed [CalcWidth-1:0] base_ext;
   logic signed [CalcWidth-1:0] corr_ext;
   logic signed [CalcWidth-1:0] pivot_ext;
   logic signed [CalcWidth-1:0] dbase_ext;
   logic signed [CalcWidth-1:0] dcorr_ext;
   logic signed [CalcWidth-1:0] ltrim_ext;
   logic signed [CalcWidth-1:0] rtrim_ext;
   logic signed [CalcWidth-1:0] l_raw;
   logic signed [CalcWidth-1:0] r_raw;
   dir_type                     ldir;
   dir_type                     rdir;
   logic                        do_stop;
   logic                        do_hold;
   logic                        line_ok;
   logic                        is_pivot;

   assign base_ext  = signed'({{(CalcWidth-DutyWidth){1'b0}}, cfg.base_duty});
   assign corr_ext  = signed'({{(CalcWidth-DutyWidth){1'b0}}, cfg.correction_duty});
   assign pivot_ext = signed'({{(CalcWidth-DutyWidth){1'b0}}, cfg.pivot_duty});
   assign dbase_ext = signed'({{(CalcWidth-DutyWidth){1'b0}}, item.direct_base});
   assign dcorr_ext = CalcWidth'(item.direct_correction);
   assign ltrim_ext = CalcWidth'(cfg.left_trim);
   assign rtrim_ext = CalcWidth'(cfg.right_trim);

   always_comb begin
      do_stop  = 1'b0;
      do_hold  = 1'b0;
      is_pivot = 1'b0;
      line_ok  = 1'b1;
      l_raw    = base_ext;
      r_raw    = base_ext;
      ldir     = DIR_FWD;
      rdir     = DIR_FWD;

      if (item.mode) begin
         l_raw = dbase_ext - dcorr_ext;
         r_raw = dbase_ext + dcorr_ext;
      end else if (item.safety_stop || !item.route_enabled) begin
         do_stop = 1'b1;
      end else if (item.control_state <= ST_TURN_LAST) begin
         // turning: act on the pending route action, anything else stops
         if (item.queued_action == ACT_STRAIGHT) begin
            l_raw = base_ext;
         end else if (item.queued_action == ACT_LEFT) begin
            is_pivot = 1'b1;
            ldir     = DIR_REV;
         end else if (item.queued_action == ACT_RIGHT ||
                      item.queued_action == ACT_AROUND) begin
            is_pivot = 1'b1;
            rdir     = DIR_REV;
         end else begin
            do_stop = 1'b1;
         end
      end else if (item.control_state == ST_COMMON_LINE &&
                   item.queued_action == ACT_LEFT) begin
         is_pivot = 1'b1;
         ldir     = DIR_REV;
      end else if (item.control_state == ST_COMMON_LINE &&
                   item.queued_action == ACT_RIGHT) begin
         is_pivot = 1'b1;
         rdir     = DIR_REV;
      end else if (item.control_state inside {[ST_COMMON_LINE:ST_MOVE_LAST]}) begin
         line_ok = 1'b0;
         if (item.line_code == LINE_CENTERED) begin
            line_ok = 1'b1;
         end else if (item.line_code == LINE_LEFT_ONLY) begin
            line_ok = 1'b1;
            l_raw   = base_ext - corr_ext;
            r_raw   = base_ext + corr_ext;
         end else if (item.line_code == LINE_RIGHT_ONLY) begin
            line_ok = 1'b1;
            l_raw   = base_ext + corr_ext;
            r_raw   = base_ext - corr_ext;
         end
         do_hold = !line_ok;
      end else begin
         do_stop = 1'b1;
      end

      if (is_pivot) begin
         l_raw = pivot_ext;
         r_raw = pivot_ext;
      end

      if (do_hold) begin
         cmd = held;
      end else if (do_stop) begin
         cmd = CMD_STOP;
      end else begin
         cmd.left_duty     = clamp_duty(l_raw + ltrim_ext, cfg.max_duty);
         cmd.right_duty    = clamp_duty(r_raw + rtrim_ext, cfg.max_duty);
         cmd.left_dir      = ldir;
         cmd.right_dir     = rdir;
         cmd.driver_enable = 1'b1;
      end
      updated = !do_hold;
   end

endmodule
